// ----- design/rlm_pkg.sv -----
// shared types, constants and helpers for the running lower median block
`default_nettype none
package rlm_pkg;

    localparam int DATA_W       = 32;
    localparam int CAPACITY_DEF = 1024;

    typedef logic signed [DATA_W-1:0] t_data;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_PUSH,
        OP_REPL
    } t_heap_op;

    typedef struct packed {
        t_heap_op op;
        t_data    value;
    } t_heap_cmd;

    typedef enum logic [2:0] {
        HS_IDLE,
        HS_UP_RD,
        HS_UP_CMP,
        HS_DN_RD,
        HS_DN_CMP
    } t_heap_state;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_RUN,
        TS_DONE
    } t_top_state;

    // a ranks above b in a max heap (is_max) or a min heap
    function automatic logic ranks_above(input logic is_max, input t_data a, input t_data b);
        ranks_above = is_max ? (a > b) : (a < b);
    endfunction

endpackage
`default_nettype wire

// ----- design/rlm_if.sv -----
// valid/ready stream interfaces for samples and medians
`default_nettype none
interface rlm_in_if;
    import rlm_pkg::*;
    logic  valid;
    logic  ready;
    t_data sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface rlm_out_if;
    import rlm_pkg::*;
    logic  valid;
    logic  ready;
    t_data median;
    logic  dropped;
    modport source (output valid, output median, output dropped, input ready);
    modport sink   (input valid, input median, input dropped, output ready);
endinterface
`default_nettype wire

// ----- design/rlm_heap.sv -----
// one binary heap in a memory with push and replace-top sequencing
`default_nettype none
module rlm_heap
    import rlm_pkg::*;
#(
    parameter int  DEPTH  = CAPACITY_DEF / 2,
    parameter bit  IS_MAX = 1'b1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_heap_cmd                  i_cmd,
    output logic                            o_busy,
    output t_data                           o_top,
    output logic [$clog2(DEPTH+1)-1:0]      o_fill
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);
    localparam int CW = (AW > FW ? AW : FW) + 2;

    t_data             mem [DEPTH];
    t_heap_state       r_state, n_state;
    logic [FW-1:0]     r_fill, n_fill;
    logic [AW-1:0]     r_pos, n_pos;
    t_data             r_val, n_val;
    t_data             r_top;
    t_data             r_rd_a, r_rd_b;
    logic              r_rv, n_rv;
    logic [AW-1:0]     r_ca, n_ca;
    logic [AW-1:0]     r_cb, n_cb;

    logic              w_en, rd_en;
    logic [AW-1:0]     w_addr, ra, rb;
    t_data             w_data;
    logic [CW-1:0]     c_l, c_r, c_fill;
    logic [AW-1:0]     parent;

    assign c_l    = {{(CW-AW){1'b0}}, r_pos} * CW'(2) + CW'(1);
    assign c_r    = c_l + CW'(1);
    assign c_fill = CW'(r_fill);
    assign parent = (r_pos - AW'(1)) >> 1;

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_pos   = r_pos;
        n_val   = r_val;
        n_rv    = r_rv;
        n_ca    = r_ca;
        n_cb    = r_cb;
        w_en    = 1'b0;
        w_addr  = r_pos;
        w_data  = r_val;
        rd_en   = 1'b0;
        ra      = r_pos;
        rb      = r_pos;
        case (r_state)
            HS_IDLE: begin
                case (i_cmd.op)
                    OP_PUSH: begin
                        n_pos   = r_fill[AW-1:0];
                        n_fill  = r_fill + FW'(1);
                        n_val   = i_cmd.value;
                        n_state = HS_UP_RD;
                    end
                    OP_REPL: begin
                        n_pos   = '0;
                        n_val   = i_cmd.value;
                        n_state = HS_DN_RD;
                    end
                    default: ;
                endcase
            end
            HS_UP_RD: begin
                if (r_pos == '0) begin
                    w_en    = 1'b1;
                    n_state = HS_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    ra      = parent;
                    n_ca    = parent;
                    n_state = HS_UP_CMP;
                end
            end
            HS_UP_CMP: begin
                w_en = 1'b1;
                if (ranks_above(IS_MAX, r_val, r_rd_a)) begin
                    w_data  = r_rd_a;
                    n_pos   = r_ca;
                    n_state = HS_UP_RD;
                end else begin
                    n_state = HS_IDLE;
                end
            end
            HS_DN_RD: begin
                if (c_l >= c_fill) begin
                    w_en    = 1'b1;
                    n_state = HS_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    ra      = c_l[AW-1:0];
                    n_rv    = c_r < c_fill;
                    rb      = (c_r < c_fill) ? c_r[AW-1:0] : c_l[AW-1:0];
                    n_ca    = c_l[AW-1:0];
                    n_cb    = rb;
                    n_state = HS_DN_CMP;
                end
            end
            HS_DN_CMP: begin
                w_en = 1'b1;
                if (r_rv && ranks_above(IS_MAX, r_rd_b, r_rd_a)
                        && ranks_above(IS_MAX, r_rd_b, r_val)) begin
                    w_data  = r_rd_b;
                    n_pos   = r_cb;
                    n_state = HS_DN_RD;
                end else if (ranks_above(IS_MAX, r_rd_a, r_val)) begin
                    w_data  = r_rd_a;
                    n_pos   = r_ca;
                    n_state = HS_DN_RD;
                end else begin
                    n_state = HS_IDLE;
                end
            end
            default: n_state = HS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= HS_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_val <= n_val;
        r_rv  <= n_rv;
        r_ca  <= n_ca;
        r_cb  <= n_cb;
        if (w_en && w_addr == '0) begin
            r_top <= w_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        if (rd_en) begin
            r_rd_a <= mem[ra];
            r_rd_b <= mem[rb];
        end
    end

    assign o_busy = (r_state != HS_IDLE);
    assign o_top  = (r_fill == '0) ? '0 : r_top;
    assign o_fill = r_fill;

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DEPTH)) else $error("heap fill beyond depth");
    a_cmd_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op != OP_NONE) |-> (r_state == HS_IDLE)) else $error("command while busy");
    a_repl_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_REPL) |-> (r_fill != '0)) else $error("replace on empty heap");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_PUSH) |-> (r_fill < FW'(DEPTH))) else $error("push on full heap");

endmodule
`default_nettype wire

// ----- design/running_lower_median.sv -----
// top level: running lower median over two memory heaps
//  channel | dir | beat payload      | accepted when
//  i_in    | in  | sample            | valid && ready
//  o_out   | out | median, dropped   | valid && ready
// one sample at a time: a new sample is not taken until the sift walk over the heap
// memory (a read state and a compare state per level) has finished and the result is loaded
// a dropped sample skips the heap walk; reset clears counts, heap memories are not cleared
// a result waiting on o_out does not block the next sample from being taken
`default_nettype none
module running_lower_median
    import rlm_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rlm_in_if.sink    i_in,
    rlm_out_if.source o_out
);
    localparam int LO_DEPTH = (CAPACITY + 1) / 2;
    localparam int UP_DEPTH = CAPACITY / 2;
    localparam int NW       = $clog2(CAPACITY + 1);
    localparam int LFW      = $clog2(LO_DEPTH + 1);
    localparam int UFW      = $clog2(UP_DEPTH + 1);

    t_top_state        r_state, n_state;
    logic [NW-1:0]     r_count, n_count;
    logic              r_drop, n_drop;
    logic              r_ovalid;
    t_data             r_median;
    logic              r_odrop;
    t_heap_cmd         lo_cmd, up_cmd;
    logic              lo_busy, up_busy;
    t_data             lo_top, up_top;
    logic [LFW-1:0]    lo_fill;
    logic [UFW-1:0]    up_fill;
    logic              in_beat, load_out;

    rlm_heap #(.DEPTH(LO_DEPTH), .IS_MAX(1'b1)) u_lower (
        .i_clk, .i_rst_n, .i_cmd(lo_cmd), .o_busy(lo_busy), .o_top(lo_top), .o_fill(lo_fill)
    );
    rlm_heap #(.DEPTH(UP_DEPTH), .IS_MAX(1'b0)) u_upper (
        .i_clk, .i_rst_n, .i_cmd(up_cmd), .o_busy(up_busy), .o_top(up_top), .o_fill(up_fill)
    );

    assign i_in.ready = (r_state == TS_IDLE);
    assign in_beat    = i_in.valid && i_in.ready;
    assign load_out   = (r_state == TS_DONE) && (!r_ovalid || o_out.ready);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_drop       = r_drop;
        lo_cmd.op    = OP_NONE;
        lo_cmd.value = i_in.sample;
        up_cmd.op    = OP_NONE;
        up_cmd.value = i_in.sample;
        case (r_state)
            TS_IDLE: begin
                if (in_beat) begin
                    if (r_count >= NW'(CAPACITY)) begin
                        n_drop  = 1'b1;
                        n_state = TS_DONE;
                    end else begin
                        n_drop  = 1'b0;
                        n_count = r_count + NW'(1);
                        n_state = TS_RUN;
                        if (r_count == '0) begin
                            lo_cmd.op = OP_PUSH;
                        end else if (r_count[0]) begin
                            if (i_in.sample < lo_top) begin
                                lo_cmd.op    = OP_REPL;
                                up_cmd.op    = OP_PUSH;
                                up_cmd.value = lo_top;
                            end else begin
                                up_cmd.op = OP_PUSH;
                            end
                        end else begin
                            if (i_in.sample > up_top) begin
                                up_cmd.op    = OP_REPL;
                                lo_cmd.op    = OP_PUSH;
                                lo_cmd.value = up_top;
                            end else begin
                                lo_cmd.op = OP_PUSH;
                            end
                        end
                    end
                end
            end
            TS_RUN: begin
                if (!lo_busy && !up_busy) begin
                    n_state = TS_DONE;
                end
            end
            TS_DONE: begin
                if (load_out) begin
                    n_state = TS_IDLE;
                end
            end
            default: n_state = TS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= TS_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_drop <= n_drop;
        if (load_out) begin
            r_median <= lo_top;
            r_odrop  <= r_drop;
        end
    end

    assign o_out.valid   = r_ovalid;
    assign o_out.median  = r_median;
    assign o_out.dropped = r_odrop;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(CAPACITY)) else $error("sample count beyond capacity");
    a_fill_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == TS_IDLE) |-> ((NW+1)'(lo_fill) + (NW+1)'(up_fill) == (NW+1)'(r_count)))
        else $error("heap fills disagree with count");
    a_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == TS_IDLE) |->
            ((NW+1)'(lo_fill) == (NW+1)'(up_fill) || (NW+1)'(lo_fill) == (NW+1)'(up_fill) + 1))
        else $error("heaps out of balance");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == TS_DONE) |-> (!lo_busy && !up_busy)) else $error("result while heap busy");

endmodule
`default_nettype wire

// ----- dv/tb_running_lower_median.sv -----
// testbench for the running lower median block: heap predictor and scoreboard
`timescale 1ns / 100ps
`default_nettype none
module tb_running_lower_median;
    import rlm_pkg::*;

    localparam int CAP       = 1024;
    localparam int LIMIT_CYC = 400000;

    logic i_clk;
    logic i_rst_n;

    rlm_in_if  in_ch ();
    rlm_out_if out_ch ();

    running_lower_median #(.CAPACITY(CAP)) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    typedef struct {
        t_data median;
        logic  dropped;
    } t_median_res;

    // predictor state
    t_data lo_heap[$];
    t_data hi_heap[$];
    int    held_cnt;

    t_median_res median_q[$];
    int  fail_cnt;
    int  sent_cnt;
    int  got_cnt;
    int  drop_cnt;
    int  cyc;
    bit  in_idle_en;
    bit  out_idle_en;
    bit  out_hold;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic bit above(bit is_max, t_data a, t_data b);
        return is_max ? (a > b) : (a < b);
    endfunction

    task automatic heap_push(ref t_data h[$], input bit is_max, input t_data v);
        int p;
        int par;
        t_data t;
        h.insert(h.size(), v);
        p = h.size() - 1;
        while (p > 0) begin
            par = (p - 1) / 2;
            if (!above(is_max, h[p], h[par])) break;
            t = h[par]; h[par] = h[p]; h[p] = t;
            p = par;
        end
    endtask

    task automatic heap_pop(ref t_data h[$], input bit is_max, output t_data top);
        int p;
        int l;
        int r;
        int b;
        t_data t;
        top = h[0];
        h[0] = h[h.size()-1];
        h.delete(h.size()-1);
        p = 0;
        forever begin
            l = 2*p + 1; r = 2*p + 2; b = p;
            if (l < h.size() && above(is_max, h[l], h[b])) b = l;
            if (r < h.size() && above(is_max, h[r], h[b])) b = r;
            if (b == p) break;
            t = h[p]; h[p] = h[b]; h[b] = t;
            p = b;
        end
    endtask

    task automatic predict_median(input t_data s);
        t_median_res res;
        t_data m;
        t_data lo_top;
        t_data hi_top;
        res.dropped = 1'b0;
        if (held_cnt >= CAP) begin
            res.dropped = 1'b1;
        end else begin
            lo_top = lo_heap.size() ? lo_heap[0] : '0;
            hi_top = hi_heap.size() ? hi_heap[0] : '0;
            if (held_cnt == 0) begin
                heap_push(lo_heap, 1, s);
            end else if (held_cnt[0]) begin
                if (s < lo_top) begin
                    heap_pop(lo_heap, 1, m);
                    heap_push(hi_heap, 0, m);
                    heap_push(lo_heap, 1, s);
                end else begin
                    heap_push(hi_heap, 0, s);
                end
            end else begin
                if (s > hi_top) begin
                    heap_pop(hi_heap, 0, m);
                    heap_push(lo_heap, 1, m);
                    heap_push(hi_heap, 0, s);
                end else begin
                    heap_push(lo_heap, 1, s);
                end
            end
            held_cnt++;
        end
        res.median = lo_heap.size() ? lo_heap[0] : '0;
        median_q.insert(median_q.size(), res);
    endtask

    task automatic send_sample(input t_data s);
        while (in_idle_en && $urandom_range(99) < 27) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.sample <= s;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_median(s);
        sent_cnt++;
    endtask

    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        while (median_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_data rand_sample();
        case ($urandom_range(3))
            0: return $urandom_range(20) - 10;
            1: return $urandom_range(3) == 0 ? 32'sh7fffffff : 32'sh80000000;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_directed();
        t_data vals[$] = '{32'sh80000000, 32'sh7fffffff, 0, -1, 1, 5, 5, 5, -5,
                           32'sh7fffffff, 32'sh80000000, 32'sh55555555,
                           32'shaaaaaaaa, 3, 3, -3, 100, -100, 7, 7};
        foreach (vals[k]) send_sample(vals[k]);
        wait_drain();
    endtask

    task automatic test_backpressure();
        out_hold = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                out_hold = 1'b0;
            end
            repeat (30) send_sample($urandom());
        join
        wait_drain();
    endtask

    task automatic test_random(input int n);
        for (int k = 0; k < n; k++) begin
            if (k == n/2) in_idle_en = 1'b0;
            if (k == n/2) out_idle_en = 1'b0;
            if (k == n/2 + 150) begin
                in_idle_en = 1'b1;
                out_idle_en = 1'b1;
            end
            send_sample(rand_sample());
        end
        wait_drain();
    endtask

    task automatic test_capacity_full();
        while (held_cnt < CAP) send_sample(rand_sample());
        repeat (280) send_sample(rand_sample());
        wait_drain();
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_median_res exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got_cnt++;
            if (out_ch.dropped) drop_cnt++;
            if (median_q.size() == 0) begin
                $display("%0t: unexpected beat median=%0d dropped=%0b", $time,
                         out_ch.median, out_ch.dropped);
                fail_cnt++;
            end else begin
                exp_r = median_q.pop_front();
                if (exp_r.median !== out_ch.median || exp_r.dropped !== out_ch.dropped) begin
                    $display("%0t: expected median=%0d dropped=%0b, got median=%0d dropped=%0b",
                             $time, exp_r.median, exp_r.dropped, out_ch.median, out_ch.dropped);
                    fail_cnt++;
                end
            end
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        out_ch.ready <= !out_hold && !(out_idle_en && $urandom_range(99) < 27);
    end

    // timeout
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > LIMIT_CYC) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        fail_cnt = 0; sent_cnt = 0; got_cnt = 0; drop_cnt = 0; held_cnt = 0; cyc = 0;
        in_idle_en = 1'b1; out_idle_en = 1'b1; out_hold = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.sample = '0;
        out_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random(700);
        test_capacity_full();
        repeat (50) @(posedge i_clk);
        $display("sent %0d samples, checked %0d medians, %0d past capacity",
                 sent_cnt, got_cnt, drop_cnt);
        if (fail_cnt == 0 && median_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
`default_nettype wire
